// ----- hw/rtl/rrte_pkg.sv -----
// rrte_pkg: shared types and constants of the route request table engine
// no dependencies
package rrte_pkg;

   localparam int RouteDepthDefault = 16;
   localparam int SeenDepth = 16;
   localparam int SeenIdxW = 4;

   typedef enum logic [1:0] {
      FUNC_RREQ   = 2'd0,
      FUNC_RREP   = 2'd1,
      FUNC_NEIGH  = 2'd2,
      FUNC_REMOVE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_IGNORE  = 2'd1,
      ACT_REPLY   = 2'd2,
      ACT_REBCAST = 2'd3
   } action_type;

   localparam int CSR_OWN_ADDR = 0;
   localparam int CSR_GW_ADDR  = 1;

   // route entry: dest, seq, expiry, next hop, hops
   typedef struct packed {
      logic [7:0]  dest;
      logic [7:0]  seq;
      logic [15:0] expiry;
      logic [7:0]  relay;
      logic [7:0]  hops;
   } route_type;

   localparam int RouteW = $bits(route_type);

endpackage

// ----- hw/rtl/route_request_table_engine.sv -----
// route_request_table_engine: top level, sequencer over route and seen-pair memories
// depends on rrte_pkg, rrte_ram
//
// sequence: a request scans the seen pairs and, unless it ends there, the routes, then decides;
// a reply or neighbour event scans the routes and decides; a removal compacts the routes;
// each scan reads one entry per cycle and waits for its last registered read at its end
// throughput: one word at a time, req_stall high from accept until the result is taken,
// then the block returns to idle before the next accept
// reset: synchronous, clears counts, sequence, gateway distance and reverse path;
// memory contents are not cleared, counts keep unread entries out of reach
module route_request_table_engine
   import rrte_pkg::*;
#(
   parameter int ROUTE_DEPTH = RouteDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [7:0]  req_source_addr,
   input  logic [7:0]  req_broadcast_id,
   input  logic [7:0]  req_dest_addr,
   input  logic [7:0]  req_dest_seq,
   input  logic [7:0]  req_source_seq,
   input  logic [7:0]  req_hop_count,
   input  logic [7:0]  req_prev_hop,
   input  logic [15:0] req_slot_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic        rsp_route_added,
   output logic        rsp_table_full,
   output logic [4:0]  rsp_route_count,
   output logic [7:0]  rsp_node_seq,
   output logic [7:0]  rsp_gateway_hops,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [7:0]  csr_data
);
   localparam int IdxW = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
   localparam int CntW = $clog2(ROUTE_DEPTH + 1);

   // one-hot sequencer states
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SEEN   = 8'b0000_0010, // scan seen pairs
      ST_FIND   = 8'b0000_0100, // scan routes for dest
      ST_DECIDE = 8'b0000_1000, // act on find result
      ST_COMP   = 8'b0001_0000, // compaction read/write
      ST_RESP   = 8'b0010_0000, // result waits
      ST_WAIT   = 8'b0100_0000, // not entered; the scan states handle read latency with rd_pend_ff
      ST_UNUSED = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // config
   logic [7:0] own_ff, gw_ff;

   // captured request
   func_type   func_ff;
   logic [7:0] src_ff, bid_ff, dst_ff, dseq_ff, sseq_ff, hops_ff, prev_ff;
   logic [15:0] slot_ff;

   // architectural state
   logic [CntW-1:0] total_ff, total_in;
   logic [SeenIdxW-1:0] sptr_ff;
   logic [SeenIdxW:0]   sfill_ff;
   logic [7:0] nseq_ff, gwd_ff;
   logic [40:0] rev_ff;

   // scan control
   logic [CntW-1:0] ri_ff, ri_in;       // read index
   logic [CntW-1:0] wj_ff, wj_in;       // compaction write index
   logic [SeenIdxW:0] si_ff, si_in;
   logic            rd_pend_ff, rd_pend_in; // read data valid next cycle for index rd_idx_ff
   logic [CntW-1:0] rd_idx_ff;
   logic            found_ff, found_in;
   logic [IdxW-1:0] fidx_ff, fidx_in;
   route_type       fent_ff, fent_in;

   // result
   logic [1:0] act_ff, act_in;
   logic add_ff, add_in, full_ff, full_in;

   // rams
   logic            rt_we;
   logic [IdxW-1:0] rt_wa, rt_ra;
   route_type       rt_wd, rt_rd;
   logic            sp_we;
   logic [15:0]     sp_rd, key;
   logic [SeenIdxW-1:0] sp_ra;

   rrte_ram #(.WIDTH(RouteW), .DEPTH(ROUTE_DEPTH)) u_route_ram (
      .clock(clock), .wr_en(rt_we), .wr_addr(rt_wa), .wr_data(rt_wd),
      .rd_addr(rt_ra), .rd_data(rt_rd));

   rrte_ram #(.WIDTH(16), .DEPTH(SeenDepth)) u_seen_ram (
      .clock(clock), .wr_en(sp_we), .wr_addr(sptr_ff), .wr_data(key),
      .rd_addr(sp_ra), .rd_data(sp_rd));

   assign key = {bid_ff, src_ff};
   assign req_stall = (state_ff != ST_IDLE);
   wire accept = req_valid && !req_stall;

   // candidate route for reply and neighbour events
   route_type cand;
   logic [7:0] rep_hops;
   assign rep_hops = (hops_ff == 8'hFF) ? 8'hFF : hops_ff + 8'd1;
   always_comb begin
      if (func_ff == FUNC_RREP) begin
         cand = '{dest: src_ff, seq: dseq_ff, expiry: 16'd0, relay: prev_ff,
                  hops: rep_hops};
      end else begin
         cand = '{dest: dst_ff, seq: 8'd0, expiry: slot_ff - 16'd1, relay: dst_ff,
                  hops: 8'd0};
      end
   end
   // route lookup target
   logic [7:0] target;
   assign target = (func_ff == FUNC_RREP) ? src_ff : dst_ff;

   logic rd_hit, rd_keep;
   assign rd_hit = rd_pend_ff && (rt_rd.dest == target);
   assign rd_keep = (rt_rd.dest != dst_ff) && (rt_rd.relay != dst_ff);

   // memory read address driven by scan index
   assign rt_ra = ri_ff[IdxW-1:0];
   assign sp_ra = si_ff[SeenIdxW-1:0];

   logic nseq_inc, gw_upd, sp_commit, rev_upd;

   always_comb begin
      state_in = state_ff;
      ri_in = ri_ff; wj_in = wj_ff; si_in = si_ff;
      rd_pend_in = 1'b0;
      found_in = found_ff; fidx_in = fidx_ff; fent_in = fent_ff;
      act_in = act_ff; add_in = add_ff; full_in = full_ff;
      total_in = total_ff;
      rt_we = 1'b0; rt_wa = fidx_ff; rt_wd = cand;
      sp_we = 1'b0; nseq_inc = 1'b0; gw_upd = 1'b0; sp_commit = 1'b0; rev_upd = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ri_in = '0; wj_in = '0; si_in = '0; found_in = 1'b0;
               act_in = ACT_NONE; add_in = 1'b0; full_in = 1'b0;
               unique case (func_type'(req_func))
                  FUNC_RREQ: state_in = ST_SEEN;
                  FUNC_RREP, FUNC_NEIGH: state_in = ST_FIND;
                  FUNC_REMOVE: state_in = ST_COMP;
                  default: state_in = ST_FIND;
               endcase
            end
         end
         ST_SEEN: begin
            // read si, compare previous read
            if (rd_pend_ff && sp_rd == key) begin
               act_in = ACT_IGNORE;
               state_in = ST_RESP;
            end else if (src_ff == own_ff) begin
               act_in = ACT_IGNORE;
               state_in = ST_RESP;
            end else if (si_ff < sfill_ff) begin
               rd_pend_in = 1'b1;
               si_in = si_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               sp_we = 1'b1; sp_commit = 1'b1; rev_upd = 1'b1;
               if (dst_ff == own_ff) begin
                  act_in = ACT_REPLY;
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_FIND;
               end
            end
         end
         ST_FIND: begin
            if (rd_hit) begin
               found_in = 1'b1;
               fidx_in = rd_idx_ff[IdxW-1:0];
               fent_in = rt_rd;
               state_in = ST_DECIDE;
            end else if (ri_ff < total_ff) begin
               rd_pend_in = 1'b1;
               ri_in = ri_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_RESP;
            unique case (func_ff)
               FUNC_RREQ: begin
                  act_in = (found_ff && !(fent_ff.seq < dseq_ff)) ? ACT_REPLY : ACT_REBCAST;
               end
               FUNC_RREP: begin
                  logic take;
                  take = (src_ff != own_ff) &&
                         !(found_ff && fent_ff.seq > dseq_ff && fent_ff.hops < rep_hops);
                  if (take) begin
                     if (found_ff) begin
                        rt_we = 1'b1; add_in = 1'b1;
                     end else if (total_ff >= CntW'(ROUTE_DEPTH)) begin
                        full_in = 1'b1;
                     end else begin
                        rt_we = 1'b1; rt_wa = total_ff[IdxW-1:0];
                        total_in = total_ff + 1'b1; add_in = 1'b1;
                     end
                  end
                  nseq_inc = rt_we;
                  gw_upd = rt_we && (src_ff == gw_ff);
                  act_in = (dst_ff == own_ff) ? ACT_NONE : (rt_we ? ACT_REPLY : ACT_NONE);
               end
               FUNC_NEIGH: begin
                  nseq_inc = 1'b1;
                  if (dst_ff != own_ff) begin
                     if (found_ff) begin
                        if (fent_ff.hops != 8'd0) begin
                           rt_we = 1'b1; add_in = 1'b1;
                        end
                     end else if (total_ff >= CntW'(ROUTE_DEPTH)) begin
                        full_in = 1'b1;
                     end else begin
                        rt_we = 1'b1; rt_wa = total_ff[IdxW-1:0];
                        total_in = total_ff + 1'b1; add_in = 1'b1;
                     end
                  end
               end
               FUNC_REMOVE: ;
               default: ;
            endcase
         end
         ST_COMP: begin
            // survivors of previous read are written to wj
            if (rd_pend_ff && rd_keep) begin
               rt_we = 1'b1; rt_wa = wj_ff[IdxW-1:0]; rt_wd = rt_rd;
               wj_in = wj_ff + 1'b1;
            end
            if (ri_ff < total_ff) begin
               rd_pend_in = 1'b1;
               ri_in = ri_ff + 1'b1;
            end else if (!rd_pend_ff) begin
               total_in = wj_ff;
               nseq_inc = 1'b1;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         own_ff <= 8'd1; gw_ff <= 8'd0;
         total_ff <= '0; sptr_ff <= '0; sfill_ff <= '0;
         nseq_ff <= '0; gwd_ff <= '0; rev_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_pend_ff <= rd_pend_in;
         total_ff <= total_in;
         if (csr_write) begin
            if (csr_index == 1'(CSR_OWN_ADDR)) own_ff <= csr_data;
            else gw_ff <= csr_data;
         end
         if (nseq_inc) nseq_ff <= nseq_ff + 8'd1;
         if (gw_upd) gwd_ff <= rep_hops;
         if (sp_commit) begin
            sptr_ff <= sptr_ff + 1'b1;
            if (sfill_ff < (SeenIdxW+1)'(SeenDepth)) sfill_ff <= sfill_ff + 1'b1;
         end
         if (rev_upd) rev_ff <= {1'b1, bid_ff, dst_ff, hops_ff, prev_ff, sseq_ff};
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff <= func_type'(req_func);
         src_ff <= req_source_addr; bid_ff <= req_broadcast_id; dst_ff <= req_dest_addr;
         dseq_ff <= req_dest_seq; sseq_ff <= req_source_seq; hops_ff <= req_hop_count;
         prev_ff <= req_prev_hop; slot_ff <= req_slot_count;
      end
      ri_ff <= ri_in; wj_ff <= wj_in; si_ff <= si_in;
      rd_idx_ff <= ri_ff;
      found_ff <= found_in; fidx_ff <= fidx_in; fent_ff <= fent_in;
      act_ff <= act_in; add_ff <= add_in; full_ff <= full_in;
   end

   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_action = act_ff;
   assign rsp_route_added = add_ff;
   assign rsp_table_full = full_ff;
   assign rsp_route_count = 5'(total_ff);
   assign rsp_node_seq = nseq_ff;
   assign rsp_gateway_hops = gwd_ff;

   // route count never exceeds the table
   a_total: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CntW'(ROUTE_DEPTH)) else $error("route count overflow");
   // compaction never writes ahead of its read
   a_comp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMP |-> wj_ff <= ri_ff) else $error("compaction overrun");
   // a full flag only comes with no route written
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_table_full && rsp_route_added)) else $error("full and added");
endmodule

// ----- hw/rtl/rrte_ram.sv -----
// rrte_ram: generic single port write, single port read ram with registered read
// depends on nothing
module rrte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// ----- sim/tb_route_request_table_engine.sv -----
`timescale 1ns / 1ps
// tb_route_request_table_engine: self-checking bench for the route request table engine
// depends on rrte_pkg and route_request_table_engine; predicts every result word in place
module tb_route_request_table_engine
   import rrte_pkg::*;
();

   localparam int Depth = 16;
   localparam int WatchLimit = 20000;

   // one request word as driven on the req_ ports
   typedef struct packed {
      func_type    func;
      logic [7:0]  src;
      logic [7:0]  bid;
      logic [7:0]  dest;
      logic [7:0]  dseq;
      logic [7:0]  sseq;
      logic [7:0]  hops;
      logic [7:0]  prev;
      logic [15:0] slot;
   } event_word_type;

   // one result word as seen on the rsp_ ports
   typedef struct packed {
      action_type  action;
      logic        added;
      logic        full;
      logic [4:0]  count;
      logic [7:0]  nseq;
      logic [7:0]  gwhops;
   } outcome_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = '0;
   logic [7:0]  req_source_addr = '0, req_broadcast_id = '0, req_dest_addr = '0;
   logic [7:0]  req_dest_seq = '0, req_source_seq = '0, req_hop_count = '0;
   logic [7:0]  req_prev_hop = '0;
   logic [15:0] req_slot_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_action;
   logic        rsp_route_added, rsp_table_full;
   logic [4:0]  rsp_route_count;
   logic [7:0]  rsp_node_seq, rsp_gateway_hops;
   logic        csr_write = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_data = '0;

   route_request_table_engine u_dut (.*);

   always #2 clock = ~clock;

   // predictor state, mirrors the block after reset
   route_type   routes[Depth];
   int          n_routes;
   logic [15:0] seen[16];
   int          seen_ptr, seen_cnt;
   logic [7:0]  node_sn, gw_dist, my_addr, gw_addr;

   event_word_type   pending_events[$];
   outcome_word_type expected_outcomes[$];
   int          errors = 0;
   int          idle_cycles = 0;
   int          sent = 0;
   bit          calm = 1'b0;      // no random idling while set
   int          hold_off = 0;     // long receiver stall, in cycles

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic int lookup(input logic [7:0] d);
      for (int i = 0; i < n_routes; i++)
         if (routes[i].dest == d) return i;
      return -1;
   endfunction

   // compute the result of one event and update the predicted state
   function automatic outcome_word_type route_engine_step(input event_word_type e);
      outcome_word_type o;
      route_type   r;
      int          at, j;
      logic [15:0] key;
      bit          take, hit;
      o = '0;
      case (e.func)
         FUNC_RREQ: begin
            key = {e.bid, e.src};
            hit = 1'b0;
            for (int i = 0; i < seen_cnt; i++) if (seen[i] == key) hit = 1'b1;
            if (e.src == my_addr || hit) o.action = ACT_IGNORE;
            else begin
               seen[seen_ptr] = key;
               seen_ptr = (seen_ptr + 1) % 16;
               if (seen_cnt < 16) seen_cnt++;
               if (e.dest == my_addr) o.action = ACT_REPLY;
               else begin
                  at = lookup(e.dest);
                  if (at >= 0) o.action = (routes[at].seq < e.dseq) ? ACT_REBCAST : ACT_REPLY;
                  else o.action = ACT_REBCAST;
               end
            end
         end
         FUNC_RREP: begin
            if (e.src != my_addr) begin
               r = '{dest: e.src, seq: e.dseq, expiry: 16'd0, relay: e.prev,
                     hops: (e.hops == 8'hff) ? 8'hff : e.hops + 8'd1};
               at = lookup(e.src);
               take = 1'b1;
               if (at >= 0 && routes[at].seq > e.dseq) take = routes[at].hops >= r.hops;
               if (take) begin
                  if (at < 0 && n_routes >= Depth) o.full = 1'b1;
                  else begin
                     if (at < 0) begin at = n_routes; n_routes++; end
                     routes[at] = r;
                     o.added = 1'b1;
                     node_sn++;
                     if (e.src == gw_addr) gw_dist = r.hops;
                  end
               end
            end
            o.action = (e.dest != my_addr && o.added) ? ACT_REPLY : ACT_NONE;
         end
         FUNC_NEIGH: begin
            node_sn++;
            if (e.dest != my_addr) begin
               r = '{dest: e.dest, seq: 8'd0, expiry: e.slot - 16'd1,
                     relay: e.dest, hops: 8'd0};
               at = lookup(e.dest);
               if (at < 0 && n_routes >= Depth) o.full = 1'b1;
               else if (at < 0 || routes[at].hops > 0) begin
                  if (at < 0) begin at = n_routes; n_routes++; end
                  routes[at] = r;
                  o.added = 1'b1;
               end
            end
            o.action = ACT_NONE;
         end
         default: begin
            node_sn++;
            j = 0;
            for (int i = 0; i < n_routes; i++)
               if (routes[i].dest != e.dest && routes[i].relay != e.dest) begin
                  routes[j] = routes[i];
                  j++;
               end
            n_routes = j;
            o.action = ACT_NONE;
         end
      endcase
      o.count = n_routes[4:0];
      o.nseq = node_sn;
      o.gwhops = gw_dist;
      return o;
   endfunction

   // addresses drawn mostly from a small pool so that routes and pairs collide
   function automatic logic [7:0] pick_addr();
      return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 23)) : 8'($urandom);
   endfunction

   function automatic event_word_type random_event();
      event_word_type e;
      e.func = func_type'($urandom_range(0, 3));
      if (e.func == FUNC_REMOVE && $urandom_range(0, 2) != 0) e.func = FUNC_RREP;
      e.src  = pick_addr();
      e.bid  = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      e.dest = pick_addr();
      e.dseq = 8'($urandom);
      e.sseq = 8'($urandom);
      e.hops = ($urandom_range(0, 9) == 0) ? 8'hff : 8'($urandom_range(0, 12));
      e.prev = pick_addr();
      e.slot = 16'($urandom);
      return e;
   endfunction

   function automatic event_word_type make_event(input func_type f, input logic [7:0] s,
         input logic [7:0] b, input logic [7:0] d, input logic [7:0] ds,
         input logic [7:0] h, input logic [7:0] p, input logic [15:0] sl);
      return '{func: f, src: s, bid: b, dest: d, dseq: ds, sseq: ~ds, hops: h,
               prev: p, slot: sl};
   endfunction

   // driver: presents the oldest pending word, holds it while stalled
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_outcomes.push_back(route_engine_step(pending_events.pop_front()));
            sent++;
         end
         if ((req_valid && req_stall) ) begin
            // payload stays put
         end else if (pending_events.size() > 0 && (calm || $urandom_range(0, 99) >= 9)) begin
            req_valid        <= 1'b1;
            req_func         <= pending_events[0].func;
            req_source_addr  <= pending_events[0].src;
            req_broadcast_id <= pending_events[0].bid;
            req_dest_addr    <= pending_events[0].dest;
            req_dest_seq     <= pending_events[0].dseq;
            req_source_seq   <= pending_events[0].sseq;
            req_hop_count    <= pending_events[0].hops;
            req_prev_hop     <= pending_events[0].prev;
            req_slot_count   <= pending_events[0].slot;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // note: the driver pops on acceptance, so the next word is pending_events[0]
   // only after the pop above; the presented word is refreshed the same cycle

   // monitor: checks each accepted result word against the oldest prediction
   always @(posedge clock) begin
      outcome_word_type w;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) report("unexpected word", 0, 0);
            else begin
               w = expected_outcomes.pop_front();
               if (rsp_action != w.action)
                  report("action", 32'(rsp_action), 32'(w.action));
               if (rsp_route_added != w.added)
                  report("route_added", 32'(rsp_route_added), 32'(w.added));
               if (rsp_table_full != w.full)
                  report("table_full", 32'(rsp_table_full), 32'(w.full));
               if (rsp_route_count != w.count)
                  report("route_count", 32'(rsp_route_count), 32'(w.count));
               if (rsp_node_seq != w.nseq)
                  report("node_seq", 32'(rsp_node_seq), 32'(w.nseq));
               if (rsp_gateway_hops != w.gwhops)
                  report("gateway_hops", 32'(rsp_gateway_hops), 32'(w.gwhops));
            end
         end
         if (hold_off > 0) begin
            rsp_stall <= 1'b1;
            hold_off <= hold_off - 1;
         end else rsp_stall <= !calm && ($urandom_range(0, 99) < 9);
      end
   end

   // watchdog: cycles with no accepted word on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchLimit) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic drain();
      wait (pending_events.size() == 0 && !req_valid);
      wait (expected_outcomes.size() == 0);
      repeat (80) @(posedge clock);
   endtask

   task automatic set_csr(input int idx, input logic [7:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx[0];
      csr_data  <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_OWN_ADDR) my_addr = v; else gw_addr = v;
   endtask

   initial begin
      n_routes = 0; seen_ptr = 0; seen_cnt = 0;
      node_sn = 0; gw_dist = 0; my_addr = 8'd1; gw_addr = 8'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: own source, duplicate pair, reply to self, gateway, saturation
      pending_events.push_back(make_event(FUNC_RREQ, 8'd1, 8'd0, 8'd5, 8'd0, 8'd0, 8'd2, 16'd0));
      pending_events.push_back(make_event(FUNC_RREQ, 8'd9, 8'd3, 8'd5, 8'd0, 8'd0, 8'd2, 16'd0));
      pending_events.push_back(make_event(FUNC_RREQ, 8'd9, 8'd3, 8'd5, 8'd0, 8'd0, 8'd2, 16'd0));
      pending_events.push_back(make_event(FUNC_RREQ, 8'd9, 8'd4, 8'd1, 8'd0, 8'd0, 8'd2, 16'd0));
      pending_events.push_back(make_event(FUNC_RREP, 8'd0, 8'd0, 8'd7, 8'd10, 8'hff, 8'd3,
                                          16'd0));
      pending_events.push_back(make_event(FUNC_RREP, 8'd0, 8'd0, 8'd1, 8'd12, 8'd0, 8'd3,
                                          16'd0));
      pending_events.push_back(make_event(FUNC_RREP, 8'd0, 8'd0, 8'd7, 8'd11, 8'd5, 8'd4,
                                          16'd0));
      pending_events.push_back(make_event(FUNC_RREP, 8'd1, 8'd0, 8'd7, 8'd11, 8'd5, 8'd4,
                                          16'd0));
      pending_events.push_back(make_event(FUNC_RREQ, 8'd8, 8'd1, 8'd0, 8'd200, 8'd0, 8'd4,
                                          16'd0));
      pending_events.push_back(make_event(FUNC_RREQ, 8'd8, 8'd2, 8'd0, 8'd0, 8'd0, 8'd4, 16'd0));
      pending_events.push_back(make_event(FUNC_NEIGH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                          16'd0));
      pending_events.push_back(make_event(FUNC_NEIGH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
                                          16'hffff));
      pending_events.push_back(make_event(FUNC_NEIGH, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0,
                                          16'd3));
      pending_events.push_back(make_event(FUNC_REMOVE, 8'd0, 8'd0, 8'd3, 8'd0, 8'd0, 8'd0,
                                          16'd0));
      // fill the table past its depth to see table full
      for (int i = 0; i < 18; i++)
         pending_events.push_back(make_event(FUNC_NEIGH, 8'hff, 8'hff, 8'(100 + i), 8'hff,
                                             8'hff, 8'hff, 16'hffff));
      drain();

      // random phases over several address settings, extremes included
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin set_csr(CSR_OWN_ADDR, 8'd0);   set_csr(CSR_GW_ADDR, 8'hff); end
            1: begin set_csr(CSR_OWN_ADDR, 8'hff);  set_csr(CSR_GW_ADDR, 8'd2);  end
            2: begin set_csr(CSR_OWN_ADDR, 8'd3);   set_csr(CSR_GW_ADDR, 8'd5);  end
            3: begin set_csr(CSR_OWN_ADDR, 8'($urandom)); set_csr(CSR_GW_ADDR, 8'd7); end
            default: begin set_csr(CSR_OWN_ADDR, 8'd1); set_csr(CSR_GW_ADDR, 8'd0); end
         endcase
         calm = (ph == 2);
         for (int i = 0; i < 300; i++) pending_events.push_back(random_event());
         // long receiver hold-off so the block backs up into its input
         if (ph == 1) begin
            wait (sent > 0);
            hold_off = 300;
         end
         drain();
      end

      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
